// File: hw/rtl/angle_kalman_filter_top_macros.svh
// Assertion macros used by the angle filter top level.
`ifndef ANGLE_KALMAN_FILTER_TOP_MACROS_SVH
`define ANGLE_KALMAN_FILTER_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define AKF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define AKF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hw/rtl/akf_pkg.sv
// -----------------------------------------------------------------------------
// akf_pkg
// Types, constants and arithmetic helpers for the angle filter.
// -----------------------------------------------------------------------------
`default_nettype none
package akf_pkg;

  localparam int unsigned W = 48;
  localparam logic signed [W-1:0] S48_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] S48_MIN = {1'b1, {(W-1){1'b0}}};

  localparam logic [31:0] QA_RST = 32'd4294967;
  localparam logic [31:0] QB_RST = 32'd12884902;
  localparam logic [31:0] RM_RST = 32'd128849019;

  localparam logic [1:0] CFG_QA = 2'd0;
  localparam logic [1:0] CFG_QB = 2'd1;
  localparam logic [1:0] CFG_RM = 2'd2;

  // ALU operand select codes
  localparam logic [3:0] SEL_DT   = 4'd0;
  localparam logic [3:0] SEL_RATE = 4'd1;
  localparam logic [3:0] SEL_P0   = 4'd2;
  localparam logic [3:0] SEL_P1   = 4'd3;
  localparam logic [3:0] SEL_P2   = 4'd4;
  localparam logic [3:0] SEL_P3   = 4'd5;
  localparam logic [3:0] SEL_QB   = 4'd6;
  localparam logic [3:0] SEL_K0   = 4'd7;
  localparam logic [3:0] SEL_K1   = 4'd8;
  localparam logic [3:0] SEL_Y    = 4'd9;
  localparam logic [3:0] SEL_T    = 4'd10;

  // Post-operation step codes, applied when a unit result is ready.
  localparam logic [4:0] OP_NONE       = 5'd0;
  localparam logic [4:0] OP_ANGLE_PRED = 5'd1;
  localparam logic [4:0] OP_INNER      = 5'd2;
  localparam logic [4:0] OP_COV_PRED   = 5'd3;
  localparam logic [4:0] OP_P3_PRED    = 5'd4;
  localparam logic [4:0] OP_GAIN0      = 5'd5;
  localparam logic [4:0] OP_GAIN1      = 5'd6;
  localparam logic [4:0] OP_ANGLE_CORR = 5'd7;
  localparam logic [4:0] OP_BIAS_CORR  = 5'd8;
  localparam logic [4:0] OP_P00_TERM   = 5'd9;
  localparam logic [4:0] OP_P01_TERM   = 5'd10;
  localparam logic [4:0] OP_P2_CORR    = 5'd11;
  localparam logic [4:0] OP_COV_CORR   = 5'd12;

  typedef struct packed {
    logic signed [24:0] measured_angle;
    logic signed [27:0] gyro_rate;
    logic [23:0]        time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] filtered_angle;
    logic signed [31:0] corrected_rate;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       load;      // capture input and form rate
    logic       mul_go;    // start a multiply
    logic [3:0] mul_a;
    logic [3:0] mul_b;
    logic       div_go;    // start a divide
    logic       div_sel;   // 0: P0/s, 1: P2/s
    logic [4:0] op;        // post-operation step code
  } akf_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
  } akf_sts_t;

  function automatic logic signed [W-1:0] sat48(input logic signed [W:0] v);
    if (v > $signed({1'b0, S48_MAX})) return S48_MAX;
    if (v < $signed({1'b1, S48_MIN})) return S48_MIN;
    return v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] add48(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
    return sat48({a[W-1], a} + {b[W-1], b});
  endfunction

  function automatic logic signed [W-1:0] sub48(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
    return sat48({a[W-1], a} - {b[W-1], b});
  endfunction

  // Signed from magnitude with saturation; magnitude up to 49 bits.
  function automatic logic signed [W-1:0] from_mag(input logic [W:0] m,
                                                   input logic neg);
    if (neg) begin
      if (m >= {1'b0, 1'b1, {(W-1){1'b0}}}) return S48_MIN;
      return -$signed(m[W-1:0]);
    end
    if (m > {2'b00, {(W-1){1'b1}}}) return S48_MAX;
    return m[W-1:0];
  endfunction

  // Q16.32 to Q16.16, round half up, saturate.
  function automatic logic signed [31:0] to_q16(input logic signed [W-1:0] x);
    logic signed [W:0] v;
    logic signed [W-16:0] q;
    v = {x[W-1], x} + (W+1)'(32768);
    q = v[W:16];
    if (q > $signed((W-15)'(32'h7FFFFFFF))) return 32'h7FFFFFFF;
    if (q < -$signed((W-15)'(33'h080000000))) return 32'h80000000;
    return q[31:0];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/angle_kalman_filter_top.sv
// -----------------------------------------------------------------------------
// angle_kalman_filter_top
// Two-state angle and gyro bias estimator in Q16.32 fixed point.
// -----------------------------------------------------------------------------
// Usage:
// The input channel carries one sensor sample per transaction, taken when
// in_valid is high and in_stall is low. The result channel presents one
// transaction per sample with the filtered angle and the bias-corrected rate.
// Each sample runs ten multiplies on a shared multiplier and two divides on
// a shared 80-step divider, one operation at a time. One sample is in
// flight at a time, so a new sample is only accepted once the previous
// result has been taken.
// While the receiver stalls, the result holds and no new sample is accepted.
// Configuration writes are taken at once (cfg_ready is always high) and
// must only be issued while the block is idle. Synchronous reset clears the
// estimates and covariance and restores the default noise values.
// -----------------------------------------------------------------------------
`default_nettype none
`include "angle_kalman_filter_top_macros.svh"
module angle_kalman_filter_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire akf_pkg::in_item_t    in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output akf_pkg::out_item_t        out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [31:0]          cfg_data
);
  akf_pkg::akf_cmd_t cmd;
  akf_pkg::akf_sts_t sts;
  logic busy;

  assign cfg_ready = 1'b1;

  // Sequencer drives the datapath one operation at a time.
  akf_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
                   .cmd, .sts, .busy);

  // Datapath holds state; result fields are formed from the stored angle estimate and corrected rate.
  akf_datapath u_dp (.clk, .rst_n, .cmd, .sts, .in_item(in_data),
                     .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_val(cfg_data),
                     .result(out_data));

  `AKF_ASSERT_IMP(a_no_accept_busy, clk, rst_n, busy, in_stall, "accept while busy")
  `AKF_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "result changed under stall")
  `AKF_ASSERT_IMP(a_go_exclusive, clk, rst_n, cmd.mul_go, !cmd.div_go, "both units started")
endmodule
`default_nettype wire

// File: hw/rtl/akf_mul.sv
// -----------------------------------------------------------------------------
// akf_mul
// Sequential Q16.32 multiplier: four 24x24 partial products, one per cycle.
// -----------------------------------------------------------------------------
`default_nettype none
module akf_mul (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   go,
  input  wire logic signed [47:0]     a,
  input  wire logic signed [47:0]     b,
  output logic                        done,
  output logic signed [47:0]          y
);
  logic [23:0] a_r [2];
  logic [23:0] b_r [2];
  logic        neg_r;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [96:0] acc_r;
  logic [47:0] pp_r;
  logic [1:0]  pidx_r;
  logic [47:0] ua, ub;
  logic [95:0] sh;
  logic [64:0] hm;
  logic [48:0] r;

  assign ua = a[47] ? 48'(-a) : a;
  assign ub = b[47] ? 48'(-b) : b;

  always_comb begin
    cnt_nxt = cnt_r;
    if (go) cnt_nxt = 3'd1;
    else if (cnt_r != 3'd0 && cnt_r != 3'd6) cnt_nxt = cnt_r + 3'd1;
    else if (cnt_r == 3'd6) cnt_nxt = 3'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= 3'd0;
    else cnt_r <= cnt_nxt;
  end

  // Product of step k is registered, then accumulated in the following cycle.
  always_comb begin
    case (pidx_r)
      2'd0: sh = {48'd0, pp_r};
      2'd1: sh = {24'd0, pp_r, 24'd0};
      2'd2: sh = {24'd0, pp_r, 24'd0};
      default: sh = {pp_r, 48'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (go) begin
      a_r[0] <= ua[23:0]; a_r[1] <= ua[47:24];
      b_r[0] <= ub[23:0]; b_r[1] <= ub[47:24];
      neg_r  <= a[47] ^ b[47];
      acc_r  <= '0;
    end else begin
      if (cnt_r >= 3'd1 && cnt_r <= 3'd4) begin
        pp_r   <= 48'(a_r[cnt_r[1]^cnt_r[0] ? 1'b0 : cnt_r[2]|cnt_r[1]]) *
                  48'(b_r[cnt_r == 3'd2 || cnt_r == 3'd4]);
        pidx_r <= 2'(cnt_r - 3'd1);
      end
      if (cnt_r >= 3'd2 && cnt_r <= 3'd5) acc_r <= acc_r + {1'b0, sh};
    end
  end
  // Steps: cnt 1 -> a0*b0, 2 -> a0*b1, 3 -> a1*b0, 4 -> a1*b1.

  assign hm   = acc_r[96:32];
  assign r    = (hm >= 65'(1) << 48) ? {1'b1, 48'd0} :
                {1'b0, acc_r[79:32]} + 49'(acc_r[31]);
  assign done = (cnt_r == 3'd6);
  assign y    = akf_pkg::from_mag(r, neg_r);
endmodule
`default_nettype wire

// File: hw/rtl/akf_div.sv
// -----------------------------------------------------------------------------
// akf_div
// Restoring divider for (n * 2^32) / d, one quotient bit per cycle.
// -----------------------------------------------------------------------------
`default_nettype none
module akf_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               go,
  input  wire logic signed [47:0] n,
  input  wire logic signed [47:0] d,
  output logic                    done,
  output logic signed [47:0]      q
);
  logic [79:0] num_r;
  logic [48:0] r_r, rs;
  logic [48:0] q_r, qs;
  logic [47:0] d_r;
  logic        neg_r, zero_r, busy_r, done_r;
  logic [6:0]  cnt_r;

  // A quotient already pinned at 2^48 stays pinned.
  assign rs = {r_r[47:0], num_r[79]};
  assign qs = q_r[48] ? (49'd1 << 48) : {q_r[47:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd79;
        num_r  <= {(n[47] ? 48'(-n) : n), 32'd0};
        d_r    <= d[47] ? 48'(-d) : d;
        zero_r <= (d == '0);
        neg_r  <= n[47] ^ d[47];
        r_r    <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        num_r <= {num_r[78:0], 1'b0};
        if (rs >= {1'b0, d_r}) begin
          r_r <= rs - {1'b0, d_r};
          q_r <= ((qs | 49'd1) > (49'd1 << 48)) ? (49'd1 << 48) : (qs | 49'd1);
        end else begin
          r_r <= rs;
          q_r <= (qs > (49'd1 << 48)) ? (49'd1 << 48) : qs;
        end
        if (cnt_r == 7'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r - 7'd1;
      end
    end
  end

  assign done = done_r;
  assign q    = zero_r ? '0 : akf_pkg::from_mag(q_r, neg_r);
endmodule
`default_nettype wire

// File: hw/rtl/akf_datapath.sv
// -----------------------------------------------------------------------------
// akf_datapath
// Filter state, configuration registers, shared multiplier and divider.
// -----------------------------------------------------------------------------
`default_nettype none
module akf_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire akf_pkg::akf_cmd_t   cmd,
  output akf_pkg::akf_sts_t        sts,
  input  wire akf_pkg::in_item_t   in_item,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_idx,
  input  wire logic [31:0]         cfg_val,
  output akf_pkg::out_item_t       result
);
  logic signed [47:0] ang_r, bias_r, p0_r, p1_r, p2_r, p3_r;
  logic signed [47:0] dt_r, rate_r, meas_r, k0_r, k1_r, y_r, t_r, s_r;
  logic [31:0] qa_r, qb_r, rm_r;
  logic signed [47:0] ma, mb, my, dy;

  function automatic logic signed [47:0] pick(input logic [3:0] s,
    input logic signed [47:0] dt, rate, p0, p1, p2, p3, k0, k1, y, t,
    input logic [31:0] qb);
    case (s)
      akf_pkg::SEL_DT:   return dt;
      akf_pkg::SEL_RATE: return rate;
      akf_pkg::SEL_P0:   return p0;
      akf_pkg::SEL_P1:   return p1;
      akf_pkg::SEL_P2:   return p2;
      akf_pkg::SEL_P3:   return p3;
      akf_pkg::SEL_QB:   return {16'd0, qb};
      akf_pkg::SEL_K0:   return k0;
      akf_pkg::SEL_K1:   return k1;
      akf_pkg::SEL_Y:    return y;
      default:           return t;
    endcase
  endfunction

  assign ma = pick(cmd.mul_a, dt_r, rate_r, p0_r, p1_r, p2_r, p3_r, k0_r, k1_r,
                   y_r, t_r, qb_r);
  assign mb = pick(cmd.mul_b, dt_r, rate_r, p0_r, p1_r, p2_r, p3_r, k0_r, k1_r,
                   y_r, t_r, qb_r);

  akf_mul u_mul (.clk, .rst_n, .go(cmd.mul_go), .a(ma), .b(mb),
                 .done(sts.mul_done), .y(my));
  akf_div u_div (.clk, .rst_n, .go(cmd.div_go), .n(cmd.div_sel ? p2_r : p0_r),
                 .d(s_r), .done(sts.div_done), .q(dy));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qa_r <= akf_pkg::QA_RST; qb_r <= akf_pkg::QB_RST; rm_r <= akf_pkg::RM_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        akf_pkg::CFG_QA: qa_r <= cfg_val;
        akf_pkg::CFG_QB: qb_r <= cfg_val;
        akf_pkg::CFG_RM: rm_r <= cfg_val;
        default: ;
      endcase
    end
  end

  // Step codes applied when the current unit result is ready. During the
  // prediction y_r holds dt*p11 until the innovation replaces it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r <= '0; bias_r <= '0;
      p0_r <= '0; p1_r <= '0; p2_r <= '0; p3_r <= '0;
    end else begin
      if (cmd.load) begin
        meas_r <= 48'(in_item.measured_angle) <<< 16;
        dt_r   <= {16'd0, in_item.time_step, 8'd0};
        rate_r <= akf_pkg::sub48(48'(in_item.gyro_rate) <<< 16, bias_r);
      end
      case (cmd.op)
        akf_pkg::OP_ANGLE_PRED: ang_r <= akf_pkg::add48(ang_r, my);
        akf_pkg::OP_INNER: begin
          t_r <= akf_pkg::add48(akf_pkg::sub48(akf_pkg::sub48(my, p1_r), p2_r),
                                {16'd0, qa_r});
          y_r <= my;                                  // dt*p11 kept
        end
        akf_pkg::OP_COV_PRED: begin
          p0_r <= akf_pkg::add48(p0_r, my);
          p1_r <= akf_pkg::sub48(p1_r, y_r);
          p2_r <= akf_pkg::sub48(p2_r, y_r);
        end
        akf_pkg::OP_P3_PRED: begin
          p3_r <= akf_pkg::add48(p3_r, my);
          s_r  <= akf_pkg::add48(p0_r, {16'd0, rm_r});
          y_r  <= akf_pkg::sub48(meas_r, ang_r);
        end
        akf_pkg::OP_GAIN0: k0_r <= dy;
        akf_pkg::OP_GAIN1: k1_r <= dy;
        akf_pkg::OP_ANGLE_CORR: ang_r <= akf_pkg::add48(ang_r, my);
        akf_pkg::OP_BIAS_CORR: bias_r <= akf_pkg::add48(bias_r, my);
        akf_pkg::OP_P00_TERM: t_r <= my;              // k0*p00
        akf_pkg::OP_P01_TERM: y_r <= my;              // k0*p01
        akf_pkg::OP_P2_CORR: p2_r <= akf_pkg::sub48(p2_r, my); // k1*p00
        akf_pkg::OP_COV_CORR: begin
          p3_r <= akf_pkg::sub48(p3_r, my);
          p0_r <= akf_pkg::sub48(p0_r, t_r);
          p1_r <= akf_pkg::sub48(p1_r, y_r);
        end
        default: ;
      endcase
    end
  end

  assign result.filtered_angle = akf_pkg::to_q16(ang_r);
  assign result.corrected_rate = akf_pkg::to_q16(rate_r);
endmodule
`default_nettype wire

// File: hw/rtl/akf_ctrl.sv
// -----------------------------------------------------------------------------
// akf_ctrl
// Sequencer: issues multiplies and divides in order and runs the handshake.
// -----------------------------------------------------------------------------
`default_nettype none
module akf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output akf_pkg::akf_cmd_t       cmd,
  input  wire akf_pkg::akf_sts_t  sts,
  output logic                    busy
);
  localparam logic [1:0] S_IDLE = 2'd0, S_ISSUE = 2'd1, S_WAIT = 2'd2, S_OUT = 2'd3;
  logic [1:0] st_r, st_nxt;
  logic [3:0] step_r, step_nxt;

  // Step table: units and operand selects, and op code applied at completion.
  // 0 dt*rate, 1 dt*p11, 2 dt*inner, 3 qb*dt, 4 div p0, 5 div p2,
  // 6 k0*y, 7 k1*y, 8 k0*p00, 9 k0*p01, 10 k1*p00, 11 k1*p01
  logic       is_div;
  logic [3:0] sa, sb;
  logic [4:0] fin;
  always_comb begin
    is_div = 1'b0; sa = akf_pkg::SEL_DT; sb = akf_pkg::SEL_RATE; fin = akf_pkg::OP_NONE;
    case (step_r)
      4'd0:  begin sb = akf_pkg::SEL_RATE; fin = akf_pkg::OP_ANGLE_PRED; end
      4'd1:  begin sb = akf_pkg::SEL_P3; fin = akf_pkg::OP_INNER; end
      4'd2:  begin sb = akf_pkg::SEL_T; fin = akf_pkg::OP_COV_PRED; end
      4'd3:  begin
        sa = akf_pkg::SEL_QB; sb = akf_pkg::SEL_DT; fin = akf_pkg::OP_P3_PRED;
      end
      4'd4:  begin is_div = 1'b1; fin = akf_pkg::OP_GAIN0; end
      4'd5:  begin is_div = 1'b1; fin = akf_pkg::OP_GAIN1; end
      4'd6:  begin
        sa = akf_pkg::SEL_K0; sb = akf_pkg::SEL_Y; fin = akf_pkg::OP_ANGLE_CORR;
      end
      4'd7:  begin
        sa = akf_pkg::SEL_K1; sb = akf_pkg::SEL_Y; fin = akf_pkg::OP_BIAS_CORR;
      end
      4'd8:  begin
        sa = akf_pkg::SEL_K0; sb = akf_pkg::SEL_P0; fin = akf_pkg::OP_P00_TERM;
      end
      4'd9:  begin
        sa = akf_pkg::SEL_K0; sb = akf_pkg::SEL_P1; fin = akf_pkg::OP_P01_TERM;
      end
      4'd10: begin
        sa = akf_pkg::SEL_K1; sb = akf_pkg::SEL_P0; fin = akf_pkg::OP_P2_CORR;
      end
      default: begin
        sa = akf_pkg::SEL_K1; sb = akf_pkg::SEL_P1; fin = akf_pkg::OP_COV_CORR;
      end
    endcase
  end

  always_comb begin
    st_nxt = st_r; step_nxt = step_r;
    cmd = '0; cmd.mul_a = sa; cmd.mul_b = sb; cmd.div_sel = (step_r == 4'd5);
    case (st_r)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1; step_nxt = 4'd0; st_nxt = S_ISSUE;
      end
      S_ISSUE: begin
        cmd.mul_go = !is_div; cmd.div_go = is_div; st_nxt = S_WAIT;
      end
      S_WAIT: if ((is_div && sts.div_done) || (!is_div && sts.mul_done)) begin
        cmd.op = fin;
        if (step_r == 4'd11) st_nxt = S_OUT;
        else begin step_nxt = step_r + 4'd1; st_nxt = S_ISSUE; end
      end
      S_OUT: if (!out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin st_r <= S_IDLE; step_r <= '0; end
    else begin st_r <= st_nxt; step_r <= step_nxt; end
  end

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign busy      = (st_r == S_ISSUE) || (st_r == S_WAIT);
endmodule
`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// Angle and gyro bias filter testbench
// Streams sensor samples through the filter with random handshake gaps on
// both channels and compares every result with a cycle-free Q16.32 model.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_CYCLES = 236;
  localparam int IN_BITS = $bits(akf_pkg::in_item_t);
  localparam longint CYCLE_LIMIT = 2000000;
  localparam longint Q48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint Q48_MIN = -64'sh0000_8000_0000_0000;
  localparam longint Q32_MAX = 64'sd2147483647;
  localparam longint Q32_MIN = -64'sd2147483648;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  akf_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  akf_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #4 clk = ~clk;

  angle_kalman_filter_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the filter: noise registers and Q16.32 state.
  longint angle_noise, bias_noise, meas_noise;
  longint angle_est, bias_est;
  longint cov [4];

  akf_pkg::out_item_t pending_results [$];
  int in_idle_pct = 38;
  int out_idle_pct = 38;
  int mismatches = 0;
  int results_seen = 0;
  int samples_sent = 0;
  longint cycle_count = 0;

  function automatic longint clamp48(longint v);
    if (v > Q48_MAX) return Q48_MAX;
    if (v < Q48_MIN) return Q48_MIN;
    return v;
  endfunction

  function automatic longint signed_from_mag(logic [127:0] m, logic neg);
    if (neg) begin
      if (m >= 128'h8000_0000_0000) return Q48_MIN;
      return -longint'(m[63:0]);
    end
    if (m > 128'h7FFF_FFFF_FFFF) return Q48_MAX;
    return longint'(m[63:0]);
  endfunction

  // Q16.32 product, rounded half away from zero, saturated to 48 bits.
  function automatic longint fix_mul(longint a, longint b);
    logic [127:0] ua, ub, prod;
    logic neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 128'(-a) : 128'(a);
    ub = (b < 0) ? 128'(-b) : 128'(b);
    prod = ua * ub;
    if (prod >= (128'd1 << 79)) return signed_from_mag(128'd1 << 48, neg);
    return signed_from_mag((prod + (128'd1 << 31)) >> 32, neg);
  endfunction

  // (n << 32) / d truncated toward zero; a zero divisor gives a zero gain.
  function automatic longint fix_div(longint n, longint d);
    logic [127:0] un, ud, quo;
    logic neg;
    if (d == 0) return 0;
    neg = (n < 0) != (d < 0);
    un = (n < 0) ? 128'(-n) : 128'(n);
    ud = (d < 0) ? 128'(-d) : 128'(d);
    quo = (un << 32) / ud;
    if (quo > (128'd1 << 48)) quo = 128'd1 << 48;
    return signed_from_mag(quo, neg);
  endfunction

  // Q16.32 to Q16.16 with ties toward plus infinity; the largest positive
  // 48-bit value rounds one past the 32-bit range and is clipped.
  function automatic logic [31:0] round_q16(longint x);
    longint v;
    v = (x + 32768) >>> 16;
    if (v > Q32_MAX) v = Q32_MAX;
    if (v < Q32_MIN) v = Q32_MIN;
    return v[31:0];
  endfunction

  function automatic akf_pkg::out_item_t filter_step(akf_pkg::in_item_t s);
    longint meas, gyro, dt, rate, dp11, inner, innov_var, k0, k1, innov, p00, p01;
    akf_pkg::out_item_t r;
    meas = longint'($signed(s.measured_angle)) * 65536;
    gyro = longint'($signed(s.gyro_rate)) * 65536;
    dt = longint'(s.time_step) << 8;

    // Predict.
    rate = clamp48(gyro - bias_est);
    angle_est = clamp48(angle_est + fix_mul(dt, rate));
    dp11 = fix_mul(dt, cov[3]);
    inner = clamp48(clamp48(clamp48(dp11 - cov[1]) - cov[2]) + angle_noise);
    cov[0] = clamp48(cov[0] + fix_mul(dt, inner));
    cov[1] = clamp48(cov[1] - dp11);
    cov[2] = clamp48(cov[2] - dp11);
    cov[3] = clamp48(cov[3] + fix_mul(bias_noise, dt));

    // Correct.
    innov_var = clamp48(cov[0] + meas_noise);
    k0 = fix_div(cov[0], innov_var);
    k1 = fix_div(cov[2], innov_var);
    innov = clamp48(meas - angle_est);
    angle_est = clamp48(angle_est + fix_mul(k0, innov));
    bias_est = clamp48(bias_est + fix_mul(k1, innov));
    p00 = cov[0];
    p01 = cov[1];
    cov[0] = clamp48(cov[0] - fix_mul(k0, p00));
    cov[1] = clamp48(cov[1] - fix_mul(k0, p01));
    cov[2] = clamp48(cov[2] - fix_mul(k1, p00));
    cov[3] = clamp48(cov[3] - fix_mul(k1, p01));

    r.filtered_angle = round_q16(angle_est);
    r.corrected_rate = round_q16(rate);
    return r;
  endfunction

  // Offers one sample and holds it until the filter takes it. Valid is left
  // high when no gap follows, so back-to-back samples never drop valid.
  task automatic send_sample(akf_pkg::in_item_t s);
    int gap;
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(filter_step(s));
    samples_sent++;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drops valid and waits until every outstanding result has been checked,
  // plus a margin so the filter is fully idle before a register write.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // One write transaction; valid is dropped again before the task returns.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      akf_pkg::CFG_QA: angle_noise = longint'(value);
      akf_pkg::CFG_QB: bias_noise = longint'(value);
      akf_pkg::CFG_RM: meas_noise = longint'(value);
      default: ;
    endcase
  endtask

  function automatic akf_pkg::in_item_t make_sample(int mode);
    akf_pkg::in_item_t s;
    if (mode == 0) begin
      // Typical IMU traffic: in-range angles and rates, millisecond steps.
      s.measured_angle = 25'($signed($urandom_range(23592960)) - 11796480);
      s.gyro_rate = 28'($signed($urandom_range(262144000)) - 131072000);
      s.time_step = 24'($urandom_range(400000));
    end else begin
      // Raw bit patterns across the full width of every field.
      s = IN_BITS'({$urandom(), $urandom(), $urandom()});
    end
    return s;
  endfunction

  function automatic akf_pkg::in_item_t pack_sample(int angle, int gyro, int dt);
    akf_pkg::in_item_t s;
    s.measured_angle = 25'(angle);
    s.gyro_rate = 28'(gyro);
    s.time_step = 24'(dt);
    return s;
  endfunction

  // Right after reset the covariance is zero, so with no measurement noise
  // and zero time steps the innovation variance is zero and both gains drop
  // out. The angle must simply hold.
  task automatic test_zero_divisor();
    write_reg(akf_pkg::CFG_RM, 32'd0);
    write_reg(akf_pkg::CFG_QA, 32'd0);
    send_sample(pack_sample(11796480, 131072000, 0));
    send_sample(pack_sample(-11796480, -131072000, 0));
    send_sample(pack_sample(0, 0, 0));
    drain();
    write_reg(akf_pkg::CFG_QA, akf_pkg::QA_RST);
    write_reg(akf_pkg::CFG_RM, akf_pkg::RM_RST);
  endtask

  // Field extremes: range limits, full bit-pattern limits, zero and maximum
  // time steps.
  task automatic test_field_extremes();
    send_sample(pack_sample(11796480, 0, 16777215));
    send_sample(pack_sample(-11796480, 0, 16777215));
    send_sample(pack_sample(0, 131072000, 167772));
    send_sample(pack_sample(0, -131072000, 167772));
    send_sample(pack_sample(16777215, 134217727, 1));
    send_sample(pack_sample(-16777216, -134217728, 16777215));
    send_sample(pack_sample(-1, -1, 0));
    send_sample(pack_sample(65536, 65536, 16777));
    drain();
  endtask

  // Each register at both ends of its range, plus a write to the unused
  // index, which must leave the noise settings alone.
  task automatic test_register_extremes();
    write_reg(akf_pkg::CFG_QA, 32'hFFFF_FFFF);
    write_reg(akf_pkg::CFG_QB, 32'hFFFF_FFFF);
    write_reg(akf_pkg::CFG_RM, 32'hFFFF_FFFF);
    send_sample(pack_sample(655360, 3276800, 167772));
    send_sample(pack_sample(-655360, -3276800, 16777215));
    drain();
    write_reg(akf_pkg::CFG_QA, 32'd0);
    write_reg(akf_pkg::CFG_QB, 32'd0);
    write_reg(akf_pkg::CFG_RM, 32'd0);
    send_sample(pack_sample(1310720, 655360, 16777));
    send_sample(pack_sample(-1310720, 0, 16777));
    drain();
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    send_sample(pack_sample(327680, -655360, 16777));
    drain();
    write_reg(akf_pkg::CFG_QA, akf_pkg::QA_RST);
    write_reg(akf_pkg::CFG_QB, akf_pkg::QB_RST);
    write_reg(akf_pkg::CFG_RM, akf_pkg::RM_RST);
  endtask

  // Random traffic in several register settings. One phase runs without any
  // idle cycles on either side; the last one uses raw bit patterns and
  // extreme noise values.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 2) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct = 38;
        out_idle_pct = 38;
      end
      if (phase == 4) begin
        write_reg(akf_pkg::CFG_QA, $urandom());
        write_reg(akf_pkg::CFG_QB, 32'hFFFF_FFFF);
        write_reg(akf_pkg::CFG_RM, $urandom_range(1000));
      end else if (phase > 0) begin
        write_reg(akf_pkg::CFG_QA, $urandom_range(32'h0400_0000));
        write_reg(akf_pkg::CFG_QB, $urandom_range(32'h0400_0000));
        write_reg(akf_pkg::CFG_RM, $urandom_range(32'h4000_0000));
      end
      for (int n = 0; n < 200; n++)
        send_sample(make_sample((phase == 4 || $urandom_range(9) == 0) ? 1 : 0));
      drain();
    end
  endtask

  // Result channel: compare each accepted transaction with the oldest
  // prediction, then pick the stall for the next cycle.
  always @(posedge clk) begin
    akf_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = pending_results.pop_front();
        if (want.filtered_angle !== out_data.filtered_angle ||
            want.corrected_rate !== out_data.corrected_rate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: angle exp %h got %h, rate exp %h got %h",
                     results_seen, want.filtered_angle, out_data.filtered_angle,
                     want.corrected_rate, out_data.corrected_rate);
        end
      end
    end
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    angle_noise = longint'(akf_pkg::QA_RST);
    bias_noise = longint'(akf_pkg::QB_RST);
    meas_noise = longint'(akf_pkg::RM_RST);
    angle_est = 0;
    bias_est = 0;
    foreach (cov[i]) cov[i] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_divisor();
    test_field_extremes();
    test_register_extremes();
    test_random_traffic();

    drain();
    repeat (SAMPLE_CYCLES) @(posedge clk);
    $display("Covered %0d samples and %0d results over %0d cycles,", samples_sent,
             results_seen, cycle_count);
    $display("including zero gain, register extremes and saturating inputs.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches,
               pending_results.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/akf_pkg.sv
hw/rtl/akf_mul.sv
hw/rtl/akf_div.sv
hw/rtl/akf_datapath.sv
hw/rtl/akf_ctrl.sv
hw/rtl/angle_kalman_filter_top.sv
verif/testbench.sv
